// ----- hw/rtl/clkset_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clkset_pkg
// Shared types, event and mode codes and calendar helpers for the clock
// setting controller.
// ----------------------------------------------------------------------------
package clkset_pkg;

    // Request kinds
    localparam logic [2:0] KIND_OK    = 3'd0;
    localparam logic [2:0] KIND_HOLD  = 3'd1;
    localparam logic [2:0] KIND_UP    = 3'd2;
    localparam logic [2:0] KIND_DOWN  = 3'd3;
    localparam logic [2:0] KIND_LOAD  = 3'd4;

    // Modes
    localparam logic [2:0] MODE_NORMAL   = 3'd0;
    localparam logic [2:0] MODE_HOUR     = 3'd1;
    localparam logic [2:0] MODE_MINUTE   = 3'd2;
    localparam logic [2:0] MODE_DATE     = 3'd3;
    localparam logic [2:0] MODE_MONTH    = 3'd4;
    localparam logic [2:0] MODE_YEAR     = 3'd5;
    localparam logic [2:0] MODE_AL_HOUR  = 3'd6;
    localparam logic [2:0] MODE_AL_MIN   = 3'd7;

    // Field limits
    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] MINUTE_MAX = 7'd59;
    localparam logic [6:0] MONTH_MAX  = 7'd12;
    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [6:0] FIELD_MIN0 = 7'd0;
    localparam logic [6:0] FIELD_MIN1 = 7'd1;
    localparam logic [6:0] CENTURY    = 7'd100;

    // Clock and alarm state
    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] date;
        logic [3:0] month;
        logic [6:0] year;
        logic [4:0] al_hour;
        logic [5:0] al_minute;
    } clk_state_t;

    // One input request
    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] date;
        logic [3:0] month;
        logic [6:0] year;
    } clk_req_t;

    // Wrap step: up past max gives min, down past min gives max
    function automatic logic [6:0] step_wrap(logic [6:0] v, logic [6:0] hi,
                                             logic [6:0] lo, logic up);
        logic [6:0] r;
        if (up)
        begin
            r = (v >= hi) ? lo : v + 7'd1;
        end
        else
        begin
            r = (v <= lo) ? hi : v - 7'd1;
        end
        return r;
    endfunction

    // Leap year over a 7-bit year: multiple of 4, except 100
    function automatic logic is_leap(logic [6:0] y);
        return (y[1:0] == 2'b00) && (y != CENTURY);
    endfunction

    // Days in month; unknown month codes get 28
    function automatic logic [4:0] month_len(logic [3:0] m, logic [6:0] y);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = is_leap(y) ? 5'd29 : 5'd28;
            default: len = 5'd28;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/clkset_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clkset_step
// Next-state logic: applies one button or load request to the clock and
// alarm state and flags a clock write.
// ----------------------------------------------------------------------------
module clkset_step (
    input  clkset_pkg::clk_state_t st,
    input  clkset_pkg::clk_req_t   req,
    output clkset_pkg::clk_state_t st_next,
    output logic                   wr_clock
);

    logic       up;
    logic [6:0] month_step;
    logic [4:0] len_cur;
    logic [4:0] len_new;

    assign up = (req.kind == clkset_pkg::KIND_UP);

    // Month after a step, and lengths for the current and stepped month
    assign month_step = clkset_pkg::step_wrap({3'd0, st.month}, clkset_pkg::MONTH_MAX,
                                              clkset_pkg::FIELD_MIN1, up);
    assign len_cur = clkset_pkg::month_len(st.month, st.year);
    assign len_new = clkset_pkg::month_len(month_step[3:0], st.year);

    // Decode request and update the selected field
    always_comb
    begin
        logic [6:0] tmp;
        st_next  = st;
        wr_clock = 1'b0;
        tmp      = '0;
        unique case (req.kind)
            clkset_pkg::KIND_OK:
            begin
                unique case (st.mode)
                    clkset_pkg::MODE_NORMAL: st_next.mode = clkset_pkg::MODE_HOUR;
                    clkset_pkg::MODE_HOUR:   st_next.mode = clkset_pkg::MODE_MINUTE;
                    clkset_pkg::MODE_MINUTE: st_next.mode = clkset_pkg::MODE_DATE;
                    clkset_pkg::MODE_DATE:   st_next.mode = clkset_pkg::MODE_MONTH;
                    clkset_pkg::MODE_MONTH:  st_next.mode = clkset_pkg::MODE_YEAR;
                    clkset_pkg::MODE_AL_HOUR: st_next.mode = clkset_pkg::MODE_AL_MIN;
                    default:                 st_next.mode = clkset_pkg::MODE_NORMAL;
                endcase
            end
            clkset_pkg::KIND_HOLD:
            begin
                st_next.mode = clkset_pkg::MODE_AL_HOUR;
            end
            clkset_pkg::KIND_UP, clkset_pkg::KIND_DOWN:
            begin
                unique case (st.mode)
                    clkset_pkg::MODE_HOUR:
                    begin
                        tmp = clkset_pkg::step_wrap({2'd0, st.hour}, clkset_pkg::HOUR_MAX,
                                                    clkset_pkg::FIELD_MIN0, up);
                        st_next.hour = tmp[4:0];
                        wr_clock     = 1'b1;
                    end
                    clkset_pkg::MODE_MINUTE:
                    begin
                        tmp = clkset_pkg::step_wrap({1'b0, st.minute},
                                                    clkset_pkg::MINUTE_MAX,
                                                    clkset_pkg::FIELD_MIN0, up);
                        st_next.minute = tmp[5:0];
                        wr_clock       = 1'b1;
                    end
                    clkset_pkg::MODE_DATE:
                    begin
                        tmp = clkset_pkg::step_wrap({2'd0, st.date}, {2'd0, len_cur},
                                                    clkset_pkg::FIELD_MIN1, up);
                        st_next.date = tmp[4:0];
                        wr_clock     = 1'b1;
                    end
                    clkset_pkg::MODE_MONTH:
                    begin
                        st_next.month = month_step[3:0];
                        if (st.date > len_new)
                        begin
                            st_next.date = len_new;
                        end
                        wr_clock = 1'b1;
                    end
                    clkset_pkg::MODE_YEAR:
                    begin
                        st_next.year = clkset_pkg::step_wrap(st.year, clkset_pkg::YEAR_MAX,
                                                             clkset_pkg::FIELD_MIN0, up);
                        wr_clock     = 1'b1;
                    end
                    clkset_pkg::MODE_AL_HOUR:
                    begin
                        tmp = clkset_pkg::step_wrap({2'd0, st.al_hour},
                                                    clkset_pkg::HOUR_MAX,
                                                    clkset_pkg::FIELD_MIN0, up);
                        st_next.al_hour = tmp[4:0];
                    end
                    clkset_pkg::MODE_AL_MIN:
                    begin
                        tmp = clkset_pkg::step_wrap({1'b0, st.al_minute},
                                                    clkset_pkg::MINUTE_MAX,
                                                    clkset_pkg::FIELD_MIN0, up);
                        st_next.al_minute = tmp[5:0];
                    end
                    default:
                    begin
                        st_next = st;
                    end
                endcase
            end
            clkset_pkg::KIND_LOAD:
            begin
                st_next.hour   = req.hour;
                st_next.minute = req.minute;
                st_next.date   = req.date;
                st_next.month  = req.month;
                st_next.year   = req.year;
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

endmodule

// ----- hw/rtl/clock_calendar_setting_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_calendar_setting_controller
// Button-driven time, date and alarm setting controller.
//
// Usage:
//   Requests (button events or a time load from the RTC) arrive on the input
//   channel (in_valid / in_stall); each produces exactly one result on the
//   output channel (out_valid / out_stall) carrying the mode, the clock and
//   alarm fields after the request, a clock write strobe and an alarm match.
//   A request is captured in an input register, its next state is computed
//   by compare-and-wrap logic and lands in the result register; throughput
//   is one request per cycle while the receiver does not stall. The state
//   registers update as a request moves into the result register, so a
//   request in the next cycle sees it.
//   When the receiver stalls, the result register holds; one more request
//   may wait in the input register, after which in_stall rises.
//   Reset clears mode, clock and alarm fields to zero and empties both
//   registers.
// ----------------------------------------------------------------------------
module clock_calendar_setting_controller (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] kind,
    input  logic [4:0] load_hour,
    input  logic [5:0] load_minute,
    input  logic [4:0] load_date,
    input  logic [3:0] load_month,
    input  logic [6:0] load_year,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] mode,
    output logic [4:0] cur_hour,
    output logic [5:0] cur_minute,
    output logic [4:0] cur_date,
    output logic [3:0] cur_month,
    output logic [6:0] cur_year,
    output logic [4:0] alarm_hour_out,
    output logic [5:0] alarm_minute_out,
    output logic       write_clock,
    output logic       alarm_match
);

    logic                   req_valid_reg;
    clkset_pkg::clk_req_t   req_reg;
    clkset_pkg::clk_state_t state_reg;
    clkset_pkg::clk_state_t state_next;
    logic                   wr_next;
    logic                   match_next;
    logic                   out_valid_reg;
    clkset_pkg::clk_state_t res_reg;
    logic                   res_wr_reg;
    logic                   res_match_reg;
    logic                   advance;

    // Move a request into the result register when it is empty or drained
    assign advance  = req_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !advance;

    // Next state for the held request
    clkset_step u_step (
        .st       (state_reg),
        .req      (req_reg),
        .st_next  (state_next),
        .wr_clock (wr_next)
    );

    assign match_next = (state_next.mode == clkset_pkg::MODE_NORMAL) &&
                        (state_next.hour == state_next.al_hour) &&
                        (state_next.minute == state_next.al_minute);

    // Hold valid flags and clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture request payload and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg.kind   <= kind;
            req_reg.hour   <= load_hour;
            req_reg.minute <= load_minute;
            req_reg.date   <= load_date;
            req_reg.month  <= load_month;
            req_reg.year   <= load_year;
        end
        if (advance)
        begin
            res_reg       <= state_next;
            res_wr_reg    <= wr_next;
            res_match_reg <= match_next;
        end
    end

    // Drive result ports
    assign out_valid        = out_valid_reg;
    assign mode             = res_reg.mode;
    assign cur_hour         = res_reg.hour;
    assign cur_minute       = res_reg.minute;
    assign cur_date         = res_reg.date;
    assign cur_month        = res_reg.month;
    assign cur_year         = res_reg.year;
    assign alarm_hour_out   = res_reg.al_hour;
    assign alarm_minute_out = res_reg.al_minute;
    assign write_clock      = res_wr_reg;
    assign alarm_match      = res_match_reg;

endmodule

// ----- verif/clock_setting_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_setting_checker
// Watches both channels of the clock setting controller. It keeps its own copy
// of the mode, clock and alarm fields and steps that copy on every accepted
// request. It queues the display that each request should produce and
// compares every accepted result with the oldest queued display, field by
// field.
// ----------------------------------------------------------------------------
module clock_setting_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [2:0] kind,
    input  logic [4:0] load_hour,
    input  logic [5:0] load_minute,
    input  logic [4:0] load_date,
    input  logic [3:0] load_month,
    input  logic [6:0] load_year,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] mode,
    input  logic [4:0] cur_hour,
    input  logic [5:0] cur_minute,
    input  logic [4:0] cur_date,
    input  logic [3:0] cur_month,
    input  logic [6:0] cur_year,
    input  logic [4:0] alarm_hour_out,
    input  logic [5:0] alarm_minute_out,
    input  logic       write_clock,
    input  logic       alarm_match,
    output int         fail_count,
    output int         outstanding
);

    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] date;
        logic [3:0] month;
        logic [6:0] year;
        logic [4:0] al_hour;
        logic [5:0] al_minute;
        logic       wr_strobe;
        logic       al_match;
    } display_t;

    // Shadow copy of the controller state
    logic [2:0] sh_mode;
    logic [4:0] sh_hour;
    logic [5:0] sh_minute;
    logic [4:0] sh_date;
    logic [3:0] sh_month;
    logic [6:0] sh_year;
    logic [4:0] sh_al_hour;
    logic [5:0] sh_al_minute;

    display_t expected_displays[$];
    int       mismatches = 0;

    // Up past the top gives the bottom, down past the bottom gives the top
    function automatic int wrap_step(input int v, input int hi, input int lo, input bit up);
        if (up)
        begin
            return (v >= hi) ? lo : v + 1;
        end
        return (v <= lo) ? hi : v - 1;
    endfunction

    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Unknown month codes count as 28 days
    function automatic int days_in_month(input int m, input int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 28;
        endcase
    endfunction

    // Apply one request to the shadow state and build the display it yields
    function automatic display_t advance_calendar(input logic [2:0] k, input logic [4:0] h,
                                                  input logic [5:0] mi, input logic [4:0] d,
                                                  input logic [3:0] mo, input logic [6:0] y);
        display_t r;
        int       lim;
        logic     stepped;
        bit       up;
        stepped = 1'b0;
        up      = (k == clkset_pkg::KIND_UP);
        case (k)
            clkset_pkg::KIND_OK:
            begin
                case (sh_mode)
                    clkset_pkg::MODE_NORMAL:  sh_mode = clkset_pkg::MODE_HOUR;
                    clkset_pkg::MODE_HOUR:    sh_mode = clkset_pkg::MODE_MINUTE;
                    clkset_pkg::MODE_MINUTE:  sh_mode = clkset_pkg::MODE_DATE;
                    clkset_pkg::MODE_DATE:    sh_mode = clkset_pkg::MODE_MONTH;
                    clkset_pkg::MODE_MONTH:   sh_mode = clkset_pkg::MODE_YEAR;
                    clkset_pkg::MODE_AL_HOUR: sh_mode = clkset_pkg::MODE_AL_MIN;
                    default:                  sh_mode = clkset_pkg::MODE_NORMAL;
                endcase
            end
            clkset_pkg::KIND_HOLD: sh_mode = clkset_pkg::MODE_AL_HOUR;
            clkset_pkg::KIND_UP, clkset_pkg::KIND_DOWN:
            begin
                case (sh_mode)
                    clkset_pkg::MODE_HOUR:
                    begin
                        sh_hour = 5'(wrap_step(sh_hour, clkset_pkg::HOUR_MAX,
                                               clkset_pkg::FIELD_MIN0, up));
                        stepped = 1'b1;
                    end
                    clkset_pkg::MODE_MINUTE:
                    begin
                        sh_minute = 6'(wrap_step(sh_minute, clkset_pkg::MINUTE_MAX,
                                                 clkset_pkg::FIELD_MIN0, up));
                        stepped   = 1'b1;
                    end
                    clkset_pkg::MODE_DATE:
                    begin
                        lim     = days_in_month(sh_month, sh_year);
                        sh_date = 5'(wrap_step(sh_date, lim, clkset_pkg::FIELD_MIN1, up));
                        stepped = 1'b1;
                    end
                    clkset_pkg::MODE_MONTH:
                    begin
                        // Clamp the date to the new month length
                        sh_month = 4'(wrap_step(sh_month, clkset_pkg::MONTH_MAX,
                                                clkset_pkg::FIELD_MIN1, up));
                        lim      = days_in_month(sh_month, sh_year);
                        if (sh_date > lim)
                        begin
                            sh_date = 5'(lim);
                        end
                        stepped = 1'b1;
                    end
                    clkset_pkg::MODE_YEAR:
                    begin
                        sh_year = 7'(wrap_step(sh_year, clkset_pkg::YEAR_MAX,
                                               clkset_pkg::FIELD_MIN0, up));
                        stepped = 1'b1;
                    end
                    clkset_pkg::MODE_AL_HOUR:
                    begin
                        sh_al_hour = 5'(wrap_step(sh_al_hour, clkset_pkg::HOUR_MAX,
                                                  clkset_pkg::FIELD_MIN0, up));
                    end
                    clkset_pkg::MODE_AL_MIN:
                    begin
                        sh_al_minute = 6'(wrap_step(sh_al_minute, clkset_pkg::MINUTE_MAX,
                                                    clkset_pkg::FIELD_MIN0, up));
                    end
                    default: ;
                endcase
            end
            clkset_pkg::KIND_LOAD:
            begin
                sh_hour   = h;
                sh_minute = mi;
                sh_date   = d;
                sh_month  = mo;
                sh_year   = y;
            end
            default: ;
        endcase
        r.mode      = sh_mode;
        r.hour      = sh_hour;
        r.minute    = sh_minute;
        r.date      = sh_date;
        r.month     = sh_month;
        r.year      = sh_year;
        r.al_hour   = sh_al_hour;
        r.al_minute = sh_al_minute;
        r.wr_strobe = stepped;
        r.al_match  = (sh_mode == clkset_pkg::MODE_NORMAL) && (sh_hour == sh_al_hour) &&
                      (sh_minute == sh_al_minute);
        return r;
    endfunction

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        display_t want;
        if (!rst_n)
        begin
            sh_mode      = clkset_pkg::MODE_NORMAL;
            sh_hour      = '0;
            sh_minute    = '0;
            sh_date      = '0;
            sh_month     = '0;
            sh_year      = '0;
            sh_al_hour   = '0;
            sh_al_minute = '0;
            expected_displays.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_displays.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result expected none, actual mode %0d", $time, mode);
                end
                else
                begin
                    want = expected_displays.pop_front();
                    compare_field("mode", want.mode, mode);
                    compare_field("cur_hour", want.hour, cur_hour);
                    compare_field("cur_minute", want.minute, cur_minute);
                    compare_field("cur_date", want.date, cur_date);
                    compare_field("cur_month", want.month, cur_month);
                    compare_field("cur_year", want.year, cur_year);
                    compare_field("alarm_hour_out", want.al_hour, alarm_hour_out);
                    compare_field("alarm_minute_out", want.al_minute, alarm_minute_out);
                    compare_field("write_clock", want.wr_strobe, write_clock);
                    compare_field("alarm_match", want.al_match, alarm_match);
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_displays.push_back(advance_calendar(kind, load_hour, load_minute,
                                                             load_date, load_month, load_year));
            end
            outstanding <= expected_displays.size();
            fail_count  <= mismatches;
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives button and time-load requests into the clock setting controller: a
// directed walk through every mode, wrap and clamp, then random requests
// and up/down bursts. Both channels idle at random and the receiver holds
// off once for a long stretch. Checking is done by clock_setting_checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int TOTAL_ITEMS  = 550;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 16;
    // Sender runs without gaps over this range of requests
    localparam int SEND_QUIET_FROM = 300;
    localparam int SEND_QUIET_TO   = 400;
    // Receiver hold-off and its quiet stretch, in cycles after reset
    localparam int HOLDOFF_AT      = 200;
    localparam int HOLDOFF_LEN     = 60;
    localparam int RECV_QUIET_FROM = 450;
    localparam int RECV_QUIET_TO   = 600;
    // Request kinds that the controller ignores
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] kind;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [4:0] load_date;
    logic [3:0] load_month;
    logic [6:0] load_year;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] mode;
    logic [4:0] cur_hour;
    logic [5:0] cur_minute;
    logic [4:0] cur_date;
    logic [3:0] cur_month;
    logic [6:0] cur_year;
    logic [4:0] alarm_hour_out;
    logic [5:0] alarm_minute_out;
    logic       write_clock;
    logic       alarm_match;

    int fail_count;
    int outstanding;
    int items_sent  = 0;
    int cycle_count = 0;

    clock_calendar_setting_controller DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .load_hour        (load_hour),
        .load_minute      (load_minute),
        .load_date        (load_date),
        .load_month       (load_month),
        .load_year        (load_year),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .mode             (mode),
        .cur_hour         (cur_hour),
        .cur_minute       (cur_minute),
        .cur_date         (cur_date),
        .cur_month        (cur_month),
        .cur_year         (cur_year),
        .alarm_hour_out   (alarm_hour_out),
        .alarm_minute_out (alarm_minute_out),
        .write_clock      (write_clock),
        .alarm_match      (alarm_match)
    );

    clock_setting_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .load_hour        (load_hour),
        .load_minute      (load_minute),
        .load_date        (load_date),
        .load_month       (load_month),
        .load_year        (load_year),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .mode             (mode),
        .cur_hour         (cur_hour),
        .cur_minute       (cur_minute),
        .cur_date         (cur_date),
        .cur_month        (cur_month),
        .cur_year         (cur_year),
        .alarm_hour_out   (alarm_hour_out),
        .alarm_minute_out (alarm_minute_out),
        .write_clock      (write_clock),
        .alarm_match      (alarm_match),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    // Free-running clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Give up when the run takes far too long
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_req(input logic [2:0] k, input logic [4:0] h, input logic [5:0] mi,
                            input logic [4:0] d, input logic [3:0] mo, input logic [6:0] y);
        bit rest;
        rest = (items_sent < SEND_QUIET_FROM || items_sent >= SEND_QUIET_TO) &&
               ($urandom_range(0, 99) < IDLE_PCT);
        if (rest)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        load_hour   <= h;
        load_minute <= mi;
        load_date   <= d;
        load_month  <= mo;
        load_year   <= y;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (k <= clkset_pkg::KIND_LOAD)
        begin
            items_sent++;
        end
    endtask

    // Button request with noise on the load fields
    task automatic press(input logic [2:0] k);
        send_req(k, 5'($urandom), 6'($urandom), 5'($urandom), 4'($urandom), 7'($urandom));
    endtask

    // Receiver: random stalls, one long hold-off, one stretch without stalls
    initial
    begin
        int recv_cycles;
        int hold_left;
        out_stall   = 1'b0;
        recv_cycles = 0;
        hold_left   = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            recv_cycles++;
            if (recv_cycles == HOLDOFF_AT)
            begin
                hold_left = HOLDOFF_LEN;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (recv_cycles >= RECV_QUIET_FROM && recv_cycles < RECV_QUIET_TO)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Sender: reset, directed walk, random requests, drain and verdict
    initial
    begin
        int       pick;
        int       burst;
        bit       narrow;
        logic [2:0] dir;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = clkset_pkg::KIND_OK;
        load_hour   = '0;
        load_minute = '0;
        load_date   = '0;
        load_month  = '0;
        load_year   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load all zeros: alarm matches at reset values
        send_req(clkset_pkg::KIND_LOAD, 5'd0, 6'd0, 5'd0, 4'd0, 7'd0);
        // Load all ones: every field out of range
        send_req(clkset_pkg::KIND_LOAD, 5'd31, 6'd63, 5'd31, 4'd15, 7'd127);
        // Up in normal mode does nothing; spare kinds are ignored
        press(clkset_pkg::KIND_UP);
        press(KIND_SPARE_LO);
        press(KIND_SPARE_HI);
        // Hour wraps from out of range and back down
        press(clkset_pkg::KIND_OK);
        press(clkset_pkg::KIND_UP);
        press(clkset_pkg::KIND_DOWN);
        // Minute wraps from out of range
        press(clkset_pkg::KIND_OK);
        press(clkset_pkg::KIND_UP);
        // Date with an unknown month code: 28 days
        press(clkset_pkg::KIND_OK);
        press(clkset_pkg::KIND_UP);
        press(clkset_pkg::KIND_DOWN);
        // Month steps from an unknown code, then load while in month mode
        press(clkset_pkg::KIND_OK);
        press(clkset_pkg::KIND_UP);
        send_req(clkset_pkg::KIND_LOAD, 5'd23, 6'd59, 5'd29, 4'd3, 7'd1);
        // March down to a non-leap February clamps the date
        press(clkset_pkg::KIND_DOWN);
        // Year wraps down through zero
        press(clkset_pkg::KIND_OK);
        press(clkset_pkg::KIND_DOWN);
        press(clkset_pkg::KIND_DOWN);
        // Hold from year mode, set alarm to 23:59, return to normal
        press(clkset_pkg::KIND_HOLD);
        press(clkset_pkg::KIND_DOWN);
        press(clkset_pkg::KIND_OK);
        press(clkset_pkg::KIND_DOWN);
        press(clkset_pkg::KIND_OK);

        // Random requests and up/down bursts
        while (items_sent < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                narrow = ($urandom_range(0, 3) == 0);
                send_req(clkset_pkg::KIND_LOAD,
                         narrow ? 5'($urandom_range(0, 1)) : 5'($urandom_range(0, 23)),
                         narrow ? 6'($urandom_range(0, 1)) : 6'($urandom_range(0, 59)),
                         5'($urandom_range(1, 31)), 4'($urandom_range(1, 12)),
                         7'($urandom_range(0, 99)));
            end
            else if (pick < 12)
            begin
                send_req(clkset_pkg::KIND_LOAD, 5'($urandom), 6'($urandom), 5'($urandom),
                         4'($urandom), 7'($urandom));
            end
            else if (pick < 30)
            begin
                press(clkset_pkg::KIND_OK);
            end
            else if (pick < 34)
            begin
                press(clkset_pkg::KIND_HOLD);
            end
            else if (pick < 36)
            begin
                press(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)));
            end
            else if (pick < 68)
            begin
                press(($urandom_range(0, 1) == 0) ? clkset_pkg::KIND_UP
                                                  : clkset_pkg::KIND_DOWN);
            end
            else
            begin
                // Step a field repeatedly, which may run it through its wrap point
                burst = $urandom_range(1, 40);
                dir   = ($urandom_range(0, 1) == 0) ? clkset_pkg::KIND_UP
                                                    : clkset_pkg::KIND_DOWN;
                repeat (burst) press(dir);
            end
        end
        in_valid <= 1'b0;

        // Let the last request reach the checker's count before waiting on it
        @(posedge clk);
        // Wait for every result, then wait on for any stray results
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
